/* design/bpss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bpss_pkg;

  typedef enum logic [2:0] {
    MODE_BOOT     = 3'd0,
    MODE_READY    = 3'd1,
    MODE_DEAD     = 3'd2,
    MODE_CHARGING = 3'd3,
    MODE_CHARGED  = 3'd4,
    MODE_LOWCUT   = 3'd5,
    MODE_FAULT    = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CELL_TEMP = 2'd0,
    KIND_CELL_VOLT = 2'd1,
    KIND_PACK_VOLT = 2'd2
  } kind_t;

  localparam logic [2:0] REG_TEMP_LIMIT      = 3'd0;
  localparam logic [2:0] REG_CELL_VOLT_LIMIT = 3'd1;
  localparam logic [2:0] REG_PACK_VOLT_LIMIT = 3'd2;
  localparam logic [2:0] REG_EMPTY_SOC       = 3'd3;
  localparam logic [2:0] REG_FULL_SOC        = 3'd4;

  localparam logic signed [15:0] TEMP_LIMIT_RST = 16'sd600;
  localparam logic [15:0] CELL_VOLT_LIMIT_RST   = 16'd4000;
  localparam logic [15:0] PACK_VOLT_LIMIT_RST   = 16'd20800;
  localparam logic [6:0]  EMPTY_SOC_RST         = 7'd1;
  localparam logic [6:0]  FULL_SOC_RST          = 7'd100;

  typedef struct packed {
    logic signed [15:0] temp_limit;
    logic [15:0]        cell_volt_limit;
    logic [15:0]        pack_volt_limit;
    logic [6:0]         empty_soc;
    logic [6:0]         full_soc;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         board_index;
    logic signed [15:0] cell_temp;
    logic [15:0]        cell_voltage;
    logic               last_board;
    logic [15:0]        pack_sense;
    logic               charger_present;
    logic               low_detect;
    logic [6:0]         soc_percent;
  } item_t;

endpackage
`default_nettype wire

/* design/battery_pack_state_supervisor.sv */
`timescale 1ns / 1ps
`default_nettype none
// A result is presented after its closing (last_board) beat is accepted: the beat is held
// in the input register, then the mode and fault registers load it.
// Throughput: one board item per cycle; a closing beat waits in the input
// register only while the previous result is stalled on the output side.
// Reset (rst, synchronous): limits return to defaults, mode to boot, fault record cleared.
module battery_pack_state_supervisor #(
  parameter int MAX_BOARDS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         board_index,
  input  wire logic signed [15:0] cell_temp,
  input  wire logic [15:0]        cell_voltage,
  input  wire logic               last_board,
  input  wire logic [15:0]        pack_sense,
  input  wire logic               charger_present,
  input  wire logic               low_detect,
  input  wire logic [6:0]         soc_percent,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              pack_mode,
  output logic                    fault_flag,
  output logic [1:0]              fault_kind,
  output logic signed [16:0]      fault_reading,
  output logic [2:0]              fault_board
);
  import bpss_pkg::*;

  cfg_t  cfg;
  item_t item_r;
  logic  item_vld;
  logic  proc;
  logic  load;

  bpss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a closing beat may only go ahead once the result register is free
  assign proc     = item_vld && (!item_r.last_board || !out_valid || !out_stall);
  assign in_stall = item_vld && !proc;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (load) begin
      item_vld <= 1'b1;
    end else if (proc) begin
      item_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.board_index     <= board_index;
      item_r.cell_temp       <= cell_temp;
      item_r.cell_voltage    <= cell_voltage;
      item_r.last_board      <= last_board;
      item_r.pack_sense      <= pack_sense;
      item_r.charger_present <= charger_present;
      item_r.low_detect      <= low_detect;
      item_r.soc_percent     <= soc_percent;
    end
  end

  bpss_core #(
    .MAX_BOARDS (MAX_BOARDS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item        (item_r),
    .proc        (proc),
    .mode_out    (pack_mode),
    .held_active (fault_flag),
    .held_code   (fault_kind),
    .held_value  (fault_reading),
    .held_board  (fault_board)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && item_r.last_board) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_flag_matches_mode: assert property (@(posedge clk) disable iff (rst)
    fault_flag == (pack_mode == MODE_FAULT))
    else $error("fault flag and fault mode disagree");

  a_result_from_close: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proc && item_r.last_board))
    else $error("result raised without a closing beat");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    fault_flag |-> (fault_kind != 2'd3))
    else $error("undefined fault kind recorded");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(pack_mode) && $stable(fault_reading))
    else $error("stalled result overwritten");

endmodule
`default_nettype wire

/* design/bpss_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module bpss_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output bpss_pkg::cfg_t     cfg
);
  import bpss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_limit      <= TEMP_LIMIT_RST;
      cfg.cell_volt_limit <= CELL_VOLT_LIMIT_RST;
      cfg.pack_volt_limit <= PACK_VOLT_LIMIT_RST;
      cfg.empty_soc       <= EMPTY_SOC_RST;
      cfg.full_soc        <= FULL_SOC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_LIMIT:      cfg.temp_limit      <= $signed(cfg_data);
        REG_CELL_VOLT_LIMIT: cfg.cell_volt_limit <= cfg_data;
        REG_PACK_VOLT_LIMIT: cfg.pack_volt_limit <= cfg_data;
        REG_EMPTY_SOC:       cfg.empty_soc       <= cfg_data[6:0];
        REG_FULL_SOC:        cfg.full_soc        <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/bpss_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module bpss_core #(
  parameter int MAX_BOARDS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bpss_pkg::cfg_t   cfg,
  input  wire bpss_pkg::item_t  item,
  input  wire logic             proc,
  output logic [2:0]            mode_out,
  output logic                  held_active,
  output logic [1:0]            held_code,
  output logic signed [16:0]    held_value,
  output logic [2:0]            held_board
);
  import bpss_pkg::*;

  mode_t              mode_reg, mode_next, mode_trans;
  logic               pass_hit, hit_next;
  logic [1:0]         pass_code, code_next;
  logic signed [16:0] pass_value, value_next;
  logic [2:0]         pass_board, board_next;
  logic               board_ok, temp_hit, volt_hit, pack_hit;
  logic               soc_empty, soc_full;

  // boards beyond the configured count are skipped, but still close the pass
  assign board_ok  = {2'b00, item.board_index} < 5'(MAX_BOARDS);
  assign temp_hit  = board_ok && (item.cell_temp > cfg.temp_limit);
  assign volt_hit  = board_ok && (item.cell_voltage > cfg.cell_volt_limit);
  assign pack_hit  = item.last_board && (item.pack_sense > cfg.pack_volt_limit);
  assign soc_empty = item.soc_percent < cfg.empty_soc;
  assign soc_full  = item.soc_percent >= cfg.full_soc;

  // pack over cell voltage over temperature; later beats override earlier ones
  always_comb begin
    hit_next = pass_hit | temp_hit | volt_hit | pack_hit;
    priority if (pack_hit) begin
      code_next  = KIND_PACK_VOLT;
      value_next = $signed({1'b0, item.pack_sense});
      board_next = 3'd0;
    end else if (volt_hit) begin
      code_next  = KIND_CELL_VOLT;
      value_next = $signed({1'b0, item.cell_voltage});
      board_next = item.board_index;
    end else if (temp_hit) begin
      code_next  = KIND_CELL_TEMP;
      value_next = 17'(item.cell_temp);
      board_next = item.board_index;
    end else begin
      code_next  = pass_code;
      value_next = pass_value;
      board_next = pass_board;
    end
  end

  always_comb begin
    mode_trans = mode_reg;
    unique case (mode_reg)
      MODE_BOOT: mode_trans = MODE_READY;
      MODE_READY: begin
        if (soc_empty) mode_trans = MODE_DEAD;
        else if (item.charger_present) mode_trans = MODE_CHARGING;
        else if (item.low_detect) mode_trans = MODE_LOWCUT;
      end
      MODE_DEAD: begin
        if (item.charger_present) mode_trans = MODE_CHARGING;
      end
      MODE_CHARGING: begin
        if (!item.charger_present) mode_trans = MODE_READY;
        else if (soc_full) mode_trans = MODE_CHARGED;
      end
      MODE_CHARGED: begin
        if (!item.charger_present) mode_trans = MODE_READY;
      end
      MODE_LOWCUT: begin
        if (!item.low_detect) mode_trans = MODE_READY;
        else if (soc_empty) mode_trans = MODE_DEAD;
      end
      MODE_FAULT: mode_trans = MODE_READY;
      default: mode_trans = MODE_FAULT;
    endcase
    mode_next = hit_next ? MODE_FAULT : mode_trans;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_BOOT;
      held_active <= 1'b0;
      held_code   <= '0;
      held_value  <= '0;
      held_board  <= '0;
      pass_hit    <= 1'b0;
      pass_code   <= '0;
      pass_value  <= '0;
      pass_board  <= '0;
    end else if (proc) begin
      if (item.last_board) begin
        mode_reg   <= mode_next;
        pass_hit   <= 1'b0;
        pass_code  <= '0;
        pass_value <= '0;
        pass_board <= '0;
        if (hit_next) begin
          held_active <= 1'b1;
          held_code   <= code_next;
          held_value  <= value_next;
          held_board  <= board_next;
        end else if (mode_reg == MODE_FAULT) begin
          held_active <= 1'b0;
        end
      end else begin
        pass_hit   <= hit_next;
        pass_code  <= code_next;
        pass_value <= value_next;
        pass_board <= board_next;
      end
    end
  end

  assign mode_out = mode_reg;

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import bpss_pkg::*;

  localparam int BOARDS       = 8;
  localparam int ITEMS_TARGET = 1550;
  localparam int QUIET_FROM   = ITEMS_TARGET - 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 4;

  typedef struct packed {
    mode_t              mode;
    logic               flag;
    kind_t              kind;
    logic signed [16:0] reading;
    logic [2:0]         board;
  } status_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         board_index = '0;
  logic signed [15:0] cell_temp = '0;
  logic [15:0]        cell_voltage = '0;
  logic               last_board = 1'b0;
  logic [15:0]        pack_sense = '0;
  logic               charger_present = 1'b0;
  logic               low_detect = 1'b0;
  logic [6:0]         soc_percent = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         pack_mode;
  logic               fault_flag;
  logic [1:0]         fault_kind;
  logic signed [16:0] fault_reading;
  logic [2:0]         fault_board;

  battery_pack_state_supervisor #(.MAX_BOARDS(BOARDS)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .board_index(board_index), .cell_temp(cell_temp), .cell_voltage(cell_voltage),
    .last_board(last_board), .pack_sense(pack_sense),
    .charger_present(charger_present), .low_detect(low_detect),
    .soc_percent(soc_percent),
    .out_valid(out_valid), .out_stall(out_stall),
    .pack_mode(pack_mode), .fault_flag(fault_flag), .fault_kind(fault_kind),
    .fault_reading(fault_reading), .fault_board(fault_board)
  );

  always #2 clk = ~clk;

  // Supervisor mirror: limits, mode, recorded fault and the fault pending in the open pass
  logic signed [15:0] lim_temp;
  logic [15:0]        lim_cell;
  logic [15:0]        lim_pack;
  logic [6:0]         soc_empty;
  logic [6:0]         soc_full;
  mode_t              sup_mode;
  logic               rec_on;
  kind_t              rec_kind;
  logic signed [16:0] rec_reading;
  logic [2:0]         rec_board;
  logic               pend_hit;
  kind_t              pend_kind;
  logic signed [16:0] pend_reading;
  logic [2:0]         pend_board;

  status_t expected_status[$];
  status_t want;

  bit idle_on = 1'b0;
  bit chg_now = 1'b0;
  bit low_now = 1'b0;
  int stall_left = 0;
  int n_items = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_fail = 0;
  int cycle_count = 0;

  task automatic note_fault(input kind_t k, input logic signed [16:0] r,
                            input logic [2:0] b);
    pend_hit = 1'b1;
    pend_kind = k;
    pend_reading = r;
    pend_board = b;
  endtask

  task automatic supervise(input item_t it);
    status_t st;
    if (int'(it.board_index) < BOARDS) begin
      if ($signed(it.cell_temp) > lim_temp)
        note_fault(KIND_CELL_TEMP, {it.cell_temp[15], it.cell_temp}, it.board_index);
      if (it.cell_voltage > lim_cell)
        note_fault(KIND_CELL_VOLT, {1'b0, it.cell_voltage}, it.board_index);
    end
    if (!it.last_board) return;
    if (it.pack_sense > lim_pack)
      note_fault(KIND_PACK_VOLT, {1'b0, it.pack_sense}, 3'd0);

    if (pend_hit) begin
      sup_mode = MODE_FAULT;
      rec_on = 1'b1;
      rec_kind = pend_kind;
      rec_reading = pend_reading;
      rec_board = pend_board;
    end else if (sup_mode == MODE_FAULT) begin
      sup_mode = MODE_READY;
      rec_on = 1'b0;
    end else begin
      case (sup_mode)
        MODE_BOOT: sup_mode = MODE_READY;
        MODE_READY: begin
          if (it.soc_percent < soc_empty) sup_mode = MODE_DEAD;
          else if (it.charger_present) sup_mode = MODE_CHARGING;
          else if (it.low_detect) sup_mode = MODE_LOWCUT;
        end
        MODE_DEAD: begin
          if (it.charger_present) sup_mode = MODE_CHARGING;
        end
        MODE_CHARGING: begin
          if (!it.charger_present) sup_mode = MODE_READY;
          else if (it.soc_percent >= soc_full) sup_mode = MODE_CHARGED;
        end
        MODE_CHARGED: begin
          if (!it.charger_present) sup_mode = MODE_READY;
        end
        MODE_LOWCUT: begin
          if (!it.low_detect) sup_mode = MODE_READY;
          else if (it.soc_percent < soc_empty) sup_mode = MODE_DEAD;
        end
        default: sup_mode = MODE_FAULT;
      endcase
    end

    pend_hit = 1'b0;
    pend_kind = KIND_CELL_TEMP;
    pend_reading = '0;
    pend_board = '0;

    st.mode = sup_mode;
    st.flag = rec_on;
    st.kind = rec_kind;
    st.reading = rec_reading;
    st.board = rec_board;
    expected_status.push_back(st);
  endtask

  // Hold the beat until accepted; valid stays high for a back-to-back follower
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    if (n_items >= QUIET_FROM) idle_on = 1'b0;
    if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    board_index     <= it.board_index;
    cell_temp       <= it.cell_temp;
    cell_voltage    <= it.cell_voltage;
    last_board      <= it.last_board;
    pack_sense      <= it.pack_sense;
    charger_present <= it.charger_present;
    low_detect      <= it.low_detect;
    soc_percent     <= it.soc_percent;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    supervise(it);
    n_items++;
  endtask

  // Drop valid, let every pending status come back, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_TEMP_LIMIT:      lim_temp = data;
      REG_CELL_VOLT_LIMIT: lim_cell = data;
      REG_PACK_VOLT_LIMIT: lim_pack = data;
      REG_EMPTY_SOC:       soc_empty = data[6:0];
      REG_FULL_SOC:        soc_full = data[6:0];
      default: ;
    endcase
    n_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t board_beat(input int bd, input int temp, input int volt,
                                       input bit last, input int pack, input bit chg,
                                       input bit low, input int soc);
    item_t it;
    it.board_index = 3'(bd);
    it.cell_temp = 16'(temp);
    it.cell_voltage = 16'(volt);
    it.last_board = last;
    it.pack_sense = 16'(pack);
    it.charger_present = chg;
    it.low_detect = low;
    it.soc_percent = 7'(soc);
    return it;
  endfunction

  // Clamp to a field range
  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Mostly in-limit readings; now and then right at a limit or anywhere in range
  function automatic item_t random_item(input int fault_odds);
    item_t it;
    int r;
    r = $urandom_range(1, 900);
    case ($urandom_range(0, fault_odds))
      0: it.cell_temp = 16'($urandom);
      1: it.cell_temp = 16'(clip(int'(lim_temp) + int'($urandom_range(0, 2)) - 1,
                                 -32768, 32767));
      default: it.cell_temp = 16'(clip(int'(lim_temp) - r, -32768, 32767));
    endcase
    r = $urandom_range(1, 800);
    case ($urandom_range(0, fault_odds))
      0: it.cell_voltage = 16'($urandom);
      1: it.cell_voltage = 16'(clip(int'(lim_cell) + int'($urandom_range(0, 2)) - 1,
                                    0, 65535));
      default: it.cell_voltage = 16'(clip(int'(lim_cell) - r, 0, 65535));
    endcase
    r = $urandom_range(1, 4000);
    case ($urandom_range(0, fault_odds))
      0: it.pack_sense = 16'($urandom);
      1: it.pack_sense = 16'(clip(int'(lim_pack) + int'($urandom_range(0, 2)) - 1,
                                  0, 65535));
      default: it.pack_sense = 16'(clip(int'(lim_pack) - r, 0, 65535));
    endcase
    case ($urandom_range(0, 7))
      0: it.soc_percent = 7'($urandom_range(0, 127));
      1: it.soc_percent = 7'(clip(int'(soc_empty) - 1, 0, 127));
      2: it.soc_percent = soc_empty;
      3: it.soc_percent = 7'(clip(int'(soc_full) - 1, 0, 127));
      4: it.soc_percent = soc_full;
      default: it.soc_percent = 7'($urandom_range(0, 100));
    endcase
    it.board_index = 3'($urandom_range(0, 7));
    it.charger_present = chg_now;
    it.low_detect = low_now;
    it.last_board = 1'b0;
    return it;
  endfunction

  // One pass: boards in order, or scattered indexes with early closing beats
  task automatic run_pass(input int fault_odds);
    item_t it;
    int n;
    bit noisy;
    n = $urandom_range(1, BOARDS);
    noisy = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 3) == 0) chg_now = ~chg_now;
    if ($urandom_range(0, 3) == 0) low_now = ~low_now;
    for (int k = 0; k < n; k++) begin
      it = random_item(fault_odds);
      if (!noisy) it.board_index = 3'(k);
      if (k != n - 1) begin
        it.charger_present = 1'($urandom_range(0, 1));
        it.low_detect = 1'($urandom_range(0, 1));
      end
      it.last_board = (k == n - 1) || (noisy && $urandom_range(0, 3) == 0);
      send_item(it);
    end
  endtask

  task automatic pick_limits();
    case ($urandom_range(0, 4))
      0: ;
      1: begin
        write_reg(REG_TEMP_LIMIT, 16'($urandom_range(300, 900)));
        write_reg(REG_CELL_VOLT_LIMIT, 16'($urandom_range(3500, 4500)));
        write_reg(REG_PACK_VOLT_LIMIT, 16'($urandom_range(18000, 24000)));
        write_reg(REG_EMPTY_SOC, 16'($urandom_range(0, 20)));
        write_reg(REG_FULL_SOC, 16'($urandom_range(70, 100)));
      end
      2: begin
        write_reg(REG_TEMP_LIMIT, 16'($urandom));
        write_reg(REG_CELL_VOLT_LIMIT, 16'($urandom));
        write_reg(REG_PACK_VOLT_LIMIT, 16'($urandom));
        write_reg(REG_EMPTY_SOC, 16'($urandom_range(0, 100)));
        write_reg(REG_FULL_SOC, 16'($urandom_range(0, 100)));
      end
      3: begin
        write_reg(REG_TEMP_LIMIT, $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
        write_reg(REG_CELL_VOLT_LIMIT, $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF);
        write_reg(REG_PACK_VOLT_LIMIT, $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF);
        write_reg(REG_EMPTY_SOC, $urandom_range(0, 1) ? 16'd0 : 16'd100);
        write_reg(REG_FULL_SOC, $urandom_range(0, 1) ? 16'd0 : 16'd100);
      end
      default: begin
        write_reg(REG_TEMP_LIMIT, TEMP_LIMIT_RST);
        write_reg(REG_CELL_VOLT_LIMIT, CELL_VOLT_LIMIT_RST);
        write_reg(REG_PACK_VOLT_LIMIT, PACK_VOLT_LIMIT_RST);
        write_reg(REG_EMPTY_SOC, {9'd0, EMPTY_SOC_RST});
        write_reg(REG_FULL_SOC, {9'd0, FULL_SOC_RST});
      end
    endcase
    if ($urandom_range(0, 4) == 0)
      write_reg(REG_FULL_SOC + 3'($urandom_range(1, 3)), 16'($urandom));
  endtask

  // Walk every non-fault mode transition under the reset limits
  task automatic test_mode_walk();
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 0, 50));
    send_item(board_beat(0, 250, 3700, 0, 16000, 0, 0, 50));
    send_item(board_beat(1, 300, 3800, 1, 16000, 1, 0, 50));
    send_item(board_beat(0, 250, 3700, 1, 16000, 1, 0, 100));
    send_item(board_beat(0, 250, 3700, 1, 16000, 1, 0, 100));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 0, 80));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 1, 50));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 0, 50));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 1, 50));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 1, 0));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 0, 0));
    send_item(board_beat(0, 250, 3700, 1, 16000, 1, 0, 0));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 0, 40));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 0, 0));
    send_item(board_beat(0, 250, 3700, 1, 16000, 1, 0, 10));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 0, 127));
  endtask

  // Fault capture: last fault wins, voltage beats temperature, record kept after clearing
  task automatic test_fault_capture();
    send_item(board_beat(2, 32767, 3700, 1, 16000, 0, 0, 50));
    send_item(board_beat(5, 601, 65535, 1, 16000, 0, 0, 50));
    send_item(board_beat(0, 250, 3700, 1, 16000, 0, 0, 50));
    send_item(board_beat(1, 250, 4001, 0, 16000, 0, 0, 50));
    send_item(board_beat(6, 601, 3700, 0, 16000, 0, 0, 50));
    send_item(board_beat(7, 250, 3700, 1, 65535, 0, 0, 50));
    send_item(board_beat(3, -32768, 0, 1, 0, 0, 0, 127));
    wait_drained();
  endtask

  // Limits at both ends, plus writes to unused indexes
  task automatic test_limit_extremes();
    write_reg(REG_TEMP_LIMIT, 16'h8000);
    write_reg(REG_CELL_VOLT_LIMIT, 16'hFFFF);
    write_reg(REG_PACK_VOLT_LIMIT, 16'h0000);
    write_reg(REG_EMPTY_SOC, 16'd0);
    write_reg(REG_FULL_SOC, 16'd0);
    for (int k = 1; k <= 3; k++) write_reg(REG_FULL_SOC + 3'(k), 16'hFFFF);
    send_item(board_beat(4, -1, 65535, 1, 1, 0, 0, 50));
    send_item(board_beat(0, -32768, 65535, 1, 0, 0, 0, 50));
    send_item(board_beat(0, -32768, 65535, 1, 0, 1, 0, 0));
    send_item(board_beat(0, -32768, 65535, 1, 0, 1, 0, 0));
    wait_drained();
    write_reg(REG_TEMP_LIMIT, 16'h7FFF);
    write_reg(REG_CELL_VOLT_LIMIT, 16'h0000);
    write_reg(REG_PACK_VOLT_LIMIT, 16'hFFFF);
    write_reg(REG_EMPTY_SOC, 16'd100);
    write_reg(REG_FULL_SOC, 16'd100);
    send_item(board_beat(7, 32767, 1, 1, 65535, 0, 0, 50));
    send_item(board_beat(7, 32767, 0, 1, 65535, 0, 0, 50));
    send_item(board_beat(0, 0, 0, 1, 65535, 0, 0, 99));
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int fault_odds;
    while (n_items < ITEMS_TARGET) begin
      wait_drained();
      pick_limits();
      idle_on = (n_items < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      fault_odds = ($urandom_range(0, 3) == 0) ? 6 : 80;
      repeat ($urandom_range(10, 30)) run_pass(fault_odds);
    end
  endtask

  initial begin
    lim_temp = TEMP_LIMIT_RST;
    lim_cell = CELL_VOLT_LIMIT_RST;
    lim_pack = PACK_VOLT_LIMIT_RST;
    soc_empty = EMPTY_SOC_RST;
    soc_full = FULL_SOC_RST;
    sup_mode = MODE_BOOT;
    rec_on = 1'b0;
    rec_kind = KIND_CELL_TEMP;
    rec_reading = '0;
    rec_board = '0;
    pend_hit = 1'b0;
    pend_kind = KIND_CELL_TEMP;
    pend_reading = '0;
    pend_board = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    idle_on = 1'b1;
    test_mode_walk();
    test_fault_capture();
    test_limit_extremes();
    test_random_traffic();
    wait_drained();

    $display("Sent %0d board beats and checked %0d status results", n_items, n_results);
    $display("across %0d register writes; %0d mismatches", n_writes, n_fail);
    if (n_fail == 0) begin
      $display("battery_pack_state_supervisor regression: pass");
    end else begin
      $display("battery_pack_state_supervisor regression: fail");
    end
    $finish;
  end

  task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Check each accepted status beat and drive random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $error("status beat with nothing expected (mode %0d)", pack_mode);
          n_fail++;
        end else begin
          want = expected_status.pop_front();
          compare_field("pack_mode", want.mode, pack_mode);
          compare_field("fault_flag", want.flag, fault_flag);
          compare_field("fault_kind", want.kind, fault_kind);
          compare_field("fault_reading", want.reading, fault_reading);
          compare_field("fault_board", want.board, fault_board);
          n_results++;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("battery_pack_state_supervisor regression: fail");
      $finish;
    end
  end

endmodule

/* filelist.f */
design/bpss_pkg.sv
design/bpss_cfg.sv
design/bpss_core.sv
design/battery_pack_state_supervisor.sv
tb/testbench.sv
